/* hw/rtl/assert_macros.svh */
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is low
`define RSVE_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, masked while reset is low
`define RSVE_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/rsve_pkg.sv */
// shared constants, types and codes of the ribbon strip vertex expander
package rsve_pkg;

    localparam int POS_W     = 24;
    localparam int UV_W      = 16;
    localparam int WD_W      = 16;
    localparam int COL_W     = 32;
    localparam int NV_W      = 33;
    localparam int IN_TD_W   = ((3 * POS_W + WD_W + COL_W + 7) / 8) * 8;
    localparam int OUT_TD_W  = ((3 * POS_W + COL_W + 7) / 8) * 8;
    localparam int CFG_A_W   = 2;

    localparam logic [CFG_A_W-1:0] REG_VIEW_X = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_VIEW_Y = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_VIEW_Z = 2'd2;

    localparam logic signed [UV_W-1:0] VIEW_Z_RST = 16'sd16384;

    typedef logic [2:0][NV_W-1:0] t_nvec;
    typedef logic [2:0][UV_W-1:0] t_uvec;

    typedef struct packed {
        logic  start;
        t_nvec vec;
    } t_norm_req;

    typedef struct packed {
        logic  done;
        logic  nz;
        t_uvec res;
    } t_norm_rsp;

    typedef enum logic [5:0] {
        N_IDLE  = 6'b000001,
        N_SHIFT = 6'b000010,
        N_SQ    = 6'b000100,
        N_SQRT  = 6'b001000,
        N_DIV   = 6'b010000,
        N_DONE  = 6'b100000
    } t_nstate;

    typedef enum logic [7:0] {
        T_IDLE   = 8'b00000001,
        T_DIFF   = 8'b00000010,
        T_NWAIT1 = 8'b00000100,
        T_CROSS  = 8'b00001000,
        T_CSTART = 8'b00010000,
        T_NWAIT2 = 8'b00100000,
        T_CALC   = 8'b01000000,
        T_SEND   = 8'b10000000
    } t_tstate;

endpackage

/* hw/rtl/ribbon_strip_vertex_expander_core.sv */
// Ribbon strip vertex expander: turns trail points into camera-facing strip vertex pairs.
// Each point beat carries position, width and color; the first point of a trail is stored
// and produces nothing, every later point emits the two vertices (u=0 then u=1) of the
// previous point, and the final point also emits its own pair, the plus vertex flagged
// with tlast. Points are taken one at a time, and each vertex waits for the output to
// accept it. The one shared normalizer (bit-serial 32-step square root and 15-step divide
// per component) runs on the segment direction and, when that is nonzero, once more on
// its cross with the view axis; a zero-length segment skips the cross.
// The view axis registers are written through the cfg channel; the user must write them
// only while no point is in work, which the block itself does not enforce.
module ribbon_strip_vertex_expander_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rsve_pkg::CFG_A_W-1:0]      i_cfg_addr,
    input  logic [rsve_pkg::UV_W-1:0]         i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pos_x, pos_y, pos_z, point_width, point_color
    input  logic [rsve_pkg::IN_TD_W-1:0]      s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // vert_x, vert_y, vert_z, vert_color
    output logic [rsve_pkg::OUT_TD_W-1:0]     m_axis_tdata,
    // tex_u
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);
    import rsve_pkg::*;

    localparam int SUM_W = POS_W + 3;

    t_tstate                 r_state;
    logic signed [UV_W-1:0]  r_view_x, r_view_y, r_view_z;
    logic                    r_have_prev;
    logic [2:0][POS_W-1:0]   r_prev;
    logic [WD_W-1:0]         r_prev_w;
    logic [COL_W-1:0]        r_prev_col;
    logic [2:0][POS_W-1:0]   r_cur;
    logic [WD_W-1:0]         r_cur_w;
    logic [COL_W-1:0]        r_cur_col;
    logic                    r_cur_last;
    t_uvec                   r_side;
    t_uvec                   r_x;
    t_nvec                   r_c;
    logic signed [NV_W-1:0]  r_acc;
    logic [2:0]              r_k;
    logic [1:0]              r_vtx;
    logic [1:0]              r_coord;
    logic [2:0][POS_W-1:0]   r_ov;
    logic [COL_W-1:0]        r_ocol;
    logic                    r_ou;
    logic                    r_olast;

    t_norm_req               norm_req;
    t_norm_rsp               norm_rsp;
    t_nvec                   diff;
    logic [2:0][POS_W-1:0]   in_pos;
    logic                    in_acc;

    logic signed [UV_W-1:0]  mul_a, mul_b;
    logic signed [31:0]      mul_p;
    logic signed [NV_W-1:0]  acc_n;

    logic [POS_W-1:0]        pnt;
    logic [WD_W-1:0]         pw;
    logic [UV_W-1:0]         sv;
    logic signed [32:0]      oprod;
    logic [32:0]             omag;
    logic [32:0]             ooff;
    logic                    oneg;
    logic signed [SUM_W-1:0] psum;
    logic [POS_W-1:0]        psat;
    logic                    seq_end;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == T_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_pos[i] = s_axis_tdata[i*POS_W +: POS_W];
            diff[i]   = {{(NV_W-POS_W){r_cur[i][POS_W-1]}}, r_cur[i]}
                      - {{(NV_W-POS_W){r_prev[i][POS_W-1]}}, r_prev[i]};
        end
    end

    assign norm_req.start = (r_state == T_DIFF) || (r_state == T_CSTART);
    assign norm_req.vec   = (r_state == T_DIFF) ? diff : r_c;

    rsve_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (norm_req),
        .o_rsp   (norm_rsp)
    );

    // cross = view x dir, one product per cycle
    always_comb begin
        case (r_k)
            3'd0:    begin mul_a = r_view_y; mul_b = r_x[2]; end
            3'd1:    begin mul_a = r_view_z; mul_b = r_x[1]; end
            3'd2:    begin mul_a = r_view_z; mul_b = r_x[0]; end
            3'd3:    begin mul_a = r_view_x; mul_b = r_x[2]; end
            3'd4:    begin mul_a = r_view_x; mul_b = r_x[1]; end
            3'd5:    begin mul_a = r_view_y; mul_b = r_x[0]; end
            default: begin mul_a = '0;       mul_b = '0;     end
        endcase
        mul_p = mul_a * mul_b;
        acc_n = r_k[0] ? (r_acc - {mul_p[31], mul_p}) : {mul_p[31], mul_p};
    end

    // one vertex coordinate per cycle
    always_comb begin
        pnt   = r_vtx[1] ? r_cur[r_coord] : r_prev[r_coord];
        pw    = r_vtx[1] ? r_cur_w : r_prev_w;
        sv    = r_side[r_coord];
        oprod = {{17{sv[UV_W-1]}}, sv} * {17'b0, pw};
        omag  = oprod[32] ? (~oprod + 1'b1) : oprod;
        ooff  = (omag + 33'd16384) >> 15;
        oneg  = oprod[32] ^ ~r_vtx[0];
        psum  = {{(SUM_W-POS_W){pnt[POS_W-1]}}, pnt}
              + (oneg ? -$signed({1'b0, ooff[POS_W:0]}) : $signed({1'b0, ooff[POS_W:0]}));
        if (psum > $signed({{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}})) begin
            psat = {1'b0, {(POS_W-1){1'b1}}};
        end else if (psum < -$signed({{(SUM_W-POS_W){1'b0}}, 1'b1, {(POS_W-1){1'b0}}})) begin
            psat = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            psat = psum[POS_W-1:0];
        end
    end

    assign seq_end = (r_vtx == 2'd3) || (r_vtx == 2'd1 && !r_cur_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_view_x    <= '0;
            r_view_y    <= '0;
            r_view_z    <= VIEW_Z_RST;
            r_have_prev <= 1'b0;
            r_prev      <= '0;
            r_prev_w    <= '0;
            r_prev_col  <= '0;
            r_side      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    REG_VIEW_X: r_view_x <= i_cfg_data;
                    REG_VIEW_Y: r_view_y <= i_cfg_data;
                    REG_VIEW_Z: r_view_z <= i_cfg_data;
                    default:    ;
                endcase
            end
            case (r_state)
                T_IDLE: begin
                    if (in_acc) begin
                        r_cur      <= in_pos;
                        r_cur_w    <= s_axis_tdata[3*POS_W +: WD_W];
                        r_cur_col  <= s_axis_tdata[3*POS_W+WD_W +: COL_W];
                        r_cur_last <= s_axis_tlast;
                        if (!r_have_prev) begin
                            r_side <= '0;
                            if (!s_axis_tlast) begin
                                r_prev      <= in_pos;
                                r_prev_w    <= s_axis_tdata[3*POS_W +: WD_W];
                                r_prev_col  <= s_axis_tdata[3*POS_W+WD_W +: COL_W];
                                r_have_prev <= 1'b1;
                            end
                        end else begin
                            r_state <= T_DIFF;
                        end
                    end
                end
                T_DIFF: begin
                    r_state <= T_NWAIT1;
                end
                T_NWAIT1: begin
                    if (norm_rsp.done) begin
                        r_vtx   <= '0;
                        r_coord <= '0;
                        r_k     <= '0;
                        r_x     <= norm_rsp.res;
                        r_state <= norm_rsp.nz ? T_CROSS : T_CALC;
                    end
                end
                T_CROSS: begin
                    r_acc <= acc_n;
                    if (r_k[0]) r_c[r_k[2:1]] <= acc_n;
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd5) r_state <= T_CSTART;
                end
                T_CSTART: begin
                    r_state <= T_NWAIT2;
                end
                T_NWAIT2: begin
                    if (norm_rsp.done) begin
                        // parallel or zero view keeps the old side vector
                        if (norm_rsp.nz) r_side <= norm_rsp.res;
                        r_state <= T_CALC;
                    end
                end
                T_CALC: begin
                    r_ov[r_coord] <= psat;
                    r_coord       <= r_coord + 2'd1;
                    if (r_coord == 2'd2) begin
                        r_ocol  <= r_vtx[1] ? r_cur_col : r_prev_col;
                        r_ou    <= r_vtx[0];
                        r_olast <= (r_vtx == 2'd3);
                        r_coord <= '0;
                        r_state <= T_SEND;
                    end
                end
                T_SEND: begin
                    if (m_axis_tready) begin
                        if (seq_end) begin
                            if (r_cur_last) begin
                                r_have_prev <= 1'b0;
                            end else begin
                                r_prev     <= r_cur;
                                r_prev_w   <= r_cur_w;
                                r_prev_col <= r_cur_col;
                            end
                            r_state <= T_IDLE;
                        end else begin
                            r_vtx   <= r_vtx + 2'd1;
                            r_state <= T_CALC;
                        end
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == T_SEND);
    assign m_axis_tuser  = r_ou;
    assign m_axis_tlast  = r_olast;

    always_comb begin
        m_axis_tdata = '0;
        for (int i = 0; i < 3; i++) m_axis_tdata[i*POS_W +: POS_W] = r_ov[i];
        m_axis_tdata[3*POS_W +: COL_W] = r_ocol;
    end

endmodule

/* hw/rtl/rsve_norm.sv */
// iterative vector normalizer: scale, sum of squares, bit-serial isqrt and divide
module rsve_norm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsve_pkg::t_norm_req i_req,
    output rsve_pkg::t_norm_rsp o_rsp
);
    import rsve_pkg::*;

    t_nstate            r_state;
    logic [2:0][NV_W-1:0] r_m;
    logic [2:0]         r_neg;
    logic [NV_W-1:0]    r_mx;
    logic [63:0]        r_acc;
    logic [63:0]        r_n;
    logic [63:0]        r_r;
    logic [63:0]        r_bit;
    logic [4:0]         r_cnt;
    logic [1:0]         r_k;
    logic [3:0]         r_step;
    logic [31:0]        r_rem;
    logic [14:0]        r_lo;
    logic [14:0]        r_q;
    logic               r_nz;
    t_uvec              r_res;

    logic [2:0][NV_W-1:0] mag;
    logic [NV_W-1:0]    mx;
    logic [61:0]        sq;
    logic [63:0]        rb;
    logic [31:0]        len;
    logic [45:0]        num;
    logic [32:0]        rem2;
    logic               ge;
    logic [14:0]        q_n;
    logic [UV_W-1:0]    q_ext;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = i_req.vec[i][NV_W-1] ? (~i_req.vec[i] + 1'b1) : i_req.vec[i];
        end
        mx = mag[0];
        if (mag[1] > mx) mx = mag[1];
        if (mag[2] > mx) mx = mag[2];
    end

    assign sq    = r_m[r_k][30:0] * r_m[r_k][30:0];
    assign rb    = r_r + r_bit;
    assign len   = r_r[31:0];
    assign num   = {1'b0, r_m[r_k][30:0], 14'b0} + {15'b0, len[31:1]};
    assign rem2  = {r_rem, r_lo[14]};
    assign ge    = rem2 >= {1'b0, len};
    assign q_n   = {r_q[13:0], ge};
    assign q_ext = {1'b0, q_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            case (r_state)
                N_IDLE: begin
                    if (i_req.start) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= mag[i];
                        for (int i = 0; i < 3; i++) r_neg[i] <= i_req.vec[i][NV_W-1];
                        r_mx    <= mx;
                        r_nz    <= (mx != '0);
                        r_state <= (mx != '0) ? N_SHIFT : N_DONE;
                    end
                end
                N_SHIFT: begin
                    if (r_mx >= 33'h0_8000_0000) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                        r_mx <= r_mx >> 1;
                    end else if (r_mx < 33'h0_0040_0000) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 8;
                        r_mx <= r_mx << 8;
                    end else if (r_mx < 33'h0_4000_0000) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                        r_mx <= r_mx << 1;
                    end else begin
                        r_acc   <= '0;
                        r_k     <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_acc <= r_acc + {2'b0, sq};
                    if (r_k == 2'd2) begin
                        r_n     <= r_acc + {2'b0, sq};
                        r_r     <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_cnt   <= '0;
                        r_state <= N_SQRT;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                N_SQRT: begin
                    if (r_n >= rb) begin
                        r_n <= r_n - rb;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_k     <= '0;
                        r_step  <= '0;
                        r_state <= N_DIV;
                    end
                end
                N_DIV: begin
                    if (r_step == 4'd0) begin
                        // seed the remainder with the top bits, known to be below len
                        r_rem  <= {1'b0, num[45:15]};
                        r_lo   <= num[14:0];
                        r_q    <= '0;
                        r_step <= 4'd1;
                    end else begin
                        r_rem  <= ge ? 32'(rem2 - {1'b0, len}) : rem2[31:0];
                        r_lo   <= {r_lo[13:0], 1'b0};
                        r_q    <= q_n;
                        r_step <= r_step + 4'd1;
                        if (r_step == 4'd15) begin
                            r_res[r_k] <= r_neg[r_k] ? (~q_ext + 1'b1) : q_ext;
                            r_step     <= '0;
                            if (r_k == 2'd2) begin
                                r_state <= N_DONE;
                            end else begin
                                r_k <= r_k + 2'd1;
                            end
                        end
                    end
                end
                N_DONE: begin
                    r_state <= N_IDLE;
                end
                default: begin
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = (r_state == N_DONE);
    assign o_rsp.nz   = r_nz;
    assign o_rsp.res  = r_res;

endmodule

/* hw/rtl/rsve_chk.sv */
// port-level checker for the ribbon strip vertex expander, bound to the top level
`include "assert_macros.svh"

module rsve_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [rsve_pkg::OUT_TD_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          m_axis_tlast
);
    import rsve_pkg::*;

    // a stalled beat holds its payload
    `RSVE_AST_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // no new point is taken while a vertex is pending
    `RSVE_AST_IMP(a_busy_excl, s_axis_tready, !m_axis_tvalid)
    // end of trail is always the plus side vertex
    `RSVE_AST_IMP(a_last_plus, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
    // a final point is never accepted while a vertex is pending
    `RSVE_AST_NXT(a_last_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast && m_axis_tvalid, 1'b0)

endmodule

bind ribbon_strip_vertex_expander_core rsve_chk u_rsve_chk (.*);

/* tb/sv/ribbon_strip_vertex_expander_core_tb.sv */
// self-checking testbench of the ribbon strip vertex expander core
module ribbon_strip_vertex_expander_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rsve_pkg::*;

    localparam int  SETTLE_CYC = 400;
    localparam int  CYC_LIMIT  = 1000000;
    localparam longint POS_HI  = (64'sd1 <<< (POS_W - 1)) - 1;
    localparam longint POS_LO  = -(64'sd1 <<< (POS_W - 1));

    typedef longint t_vec3 [0:2];

    typedef struct {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic [COL_W-1:0] col;
        logic             u;
        logic             lst;
    } t_vert;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_A_W-1:0]   i_cfg_addr = '0;
    logic [UV_W-1:0]      i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_TD_W-1:0]   s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_TD_W-1:0]  m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    ribbon_strip_vertex_expander_core dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    longint view_x = 0, view_y = 0, view_z = 16384;
    bit     trail_open = 0;
    longint last_px = 0, last_py = 0, last_pz = 0;
    longint last_w = 0, last_col = 0;
    longint side_x = 0, side_y = 0, side_z = 0;

    t_vert  vert_q [$];
    int     n_fail = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_req = 0;
    int     hold_cnt = 0;
    int     cyc = 0;

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale to [2^30, 2^31), then round each magnitude against the length
    function automatic bit norm_q14(input t_vec3 v, output t_vec3 o);
        longint unsigned m [0:2];
        longint unsigned mx, len, q;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (m[i] > mx) mx = m[i];
            o[i] = 0;
        end
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        len = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 16384 + len / 2) / len;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic logic [POS_W-1:0] shifted_coord(input longint p, input longint side,
                                                       input longint w, input bit plus);
        longint prod, off, r;
        prod = side * w;
        off  = (((prod < 0) ? -prod : prod) + 16384) >>> 15;
        if (prod < 0) off = -off;
        r = plus ? p + off : p - off;
        if (r > POS_HI) r = POS_HI;
        if (r < POS_LO) r = POS_LO;
        return r[POS_W-1:0];
    endfunction

    task automatic push_pair(input longint px, input longint py, input longint pz,
                             input longint w, input longint col, input bit lst);
        t_vert v;
        for (int s = 0; s < 2; s++) begin
            v.x   = shifted_coord(px, side_x, w, s == 1);
            v.y   = shifted_coord(py, side_y, w, s == 1);
            v.z   = shifted_coord(pz, side_z, w, s == 1);
            v.col = col[COL_W-1:0];
            v.u   = (s == 1);
            v.lst = lst && (s == 1);
            vert_q.insert(vert_q.size(), v);
        end
    endtask

    task automatic predict_point(input longint px, input longint py, input longint pz,
                                 input longint w, input longint col, input bit lst);
        t_vec3 d, dn, c, sn;
        if (!trail_open) begin
            side_x = 0; side_y = 0; side_z = 0;
            if (!lst) begin
                last_px = px; last_py = py; last_pz = pz;
                last_w = w; last_col = col;
                trail_open = 1;
            end
            return;
        end
        d[0] = px - last_px; d[1] = py - last_py; d[2] = pz - last_pz;
        if (norm_q14(d, dn)) begin
            c[0] = view_y * dn[2] - view_z * dn[1];
            c[1] = view_z * dn[0] - view_x * dn[2];
            c[2] = view_x * dn[1] - view_y * dn[0];
            // parallel or zero view keeps the old side vector
            if (norm_q14(c, sn)) begin
                side_x = sn[0]; side_y = sn[1]; side_z = sn[2];
            end
        end
        push_pair(last_px, last_py, last_pz, last_w, last_col, 0);
        if (lst) begin
            push_pair(px, py, pz, w, col, 1);
            trail_open = 0;
        end else begin
            last_px = px; last_py = py; last_pz = pz;
            last_w = w; last_col = col;
        end
    endtask

    // receiver: random stall, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_vert e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (vert_q.size() == 0) begin
                $error("unexpected vertex beat %h", m_axis_tdata);
                n_fail++;
            end else begin
                e = vert_q.pop_front();
                if (m_axis_tdata[POS_W-1:0] !== e.x) begin
                    $error("vert_x expected %h got %h", e.x, m_axis_tdata[POS_W-1:0]);
                    n_fail++;
                end
                if (m_axis_tdata[2*POS_W-1:POS_W] !== e.y) begin
                    $error("vert_y expected %h got %h", e.y, m_axis_tdata[2*POS_W-1:POS_W]);
                    n_fail++;
                end
                if (m_axis_tdata[3*POS_W-1:2*POS_W] !== e.z) begin
                    $error("vert_z expected %h got %h", e.z,
                           m_axis_tdata[3*POS_W-1:2*POS_W]);
                    n_fail++;
                end
                if (m_axis_tdata[3*POS_W+COL_W-1:3*POS_W] !== e.col) begin
                    $error("vert_color expected %h got %h", e.col,
                           m_axis_tdata[3*POS_W+COL_W-1:3*POS_W]);
                    n_fail++;
                end
                if (m_axis_tuser !== e.u) begin
                    $error("tex_u expected %0d got %0d", e.u, m_axis_tuser);
                    n_fail++;
                end
                if (m_axis_tlast !== e.lst) begin
                    $error("last_vertex expected %0d got %0d", e.lst, m_axis_tlast);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc = cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("[ribbon_strip_vertex_expander_core] ERROR");
            $finish;
        end
    end

    task automatic send_point(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic [POS_W-1:0] z, input logic [WD_W-1:0] w,
                              input logic [COL_W-1:0] col, input bit lst);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {col, w, z, y, x};
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_point(longint'($signed(x)), longint'($signed(y)), longint'($signed(z)),
                      longint'(w), longint'(col), lst);
    endtask

    // stop offering and wait until every vertex is out and the core is quiet
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (vert_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_view(input logic [UV_W-1:0] vx, input logic [UV_W-1:0] vy,
                            input logic [UV_W-1:0] vz);
        logic [UV_W-1:0] vals [0:2];
        logic [CFG_A_W-1:0] regs [0:2];
        vals = '{vx, vy, vz};
        regs = '{REG_VIEW_X, REG_VIEW_Y, REG_VIEW_Z};
        drain();
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_addr  <= regs[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        view_x = longint'($signed(vx));
        view_y = longint'($signed(vy));
        view_z = longint'($signed(vz));
    endtask

    task automatic test_directed;
        // single point trail emits nothing
        send_point(24'h000100, 24'h000200, 24'h000300, 16'h0100, 32'h11223344, 1);
        // plain two point trail
        send_point(24'h000000, 24'h000000, 24'h000000, 16'h0200, 32'hffffffff, 0);
        send_point(24'h001000, 24'h000000, 24'h000000, 16'h0000, 32'h00000000, 1);
        // zero-length segment with no earlier side vector, then a real one
        send_point(24'h000500, 24'h000500, 24'h000500, 16'hffff, 32'h01020304, 0);
        send_point(24'h000500, 24'h000500, 24'h000500, 16'h8000, 32'h05060708, 0);
        send_point(24'h000500, 24'h000900, 24'h000500, 16'h4000, 32'h090a0b0c, 0);
        send_point(24'h000500, 24'h000900, 24'h000500, 16'h1234, 32'h0d0e0f10, 0);
        // segment along the view axis keeps the old side vector
        send_point(24'h000500, 24'h000900, 24'h009000, 16'h0800, 32'h55aa55aa, 1);
        // saturation at both ends of the range
        send_point(24'h7fffff, 24'h000000, 24'h000000, 16'hffff, 32'hdeadbeef, 0);
        send_point(24'h7fffff, 24'h000100, 24'h000000, 16'hffff, 32'hcafef00d, 1);
        send_point(24'h800000, 24'h7fffff, 24'h800000, 16'hffff, 32'h80000001, 0);
        send_point(24'h7fffff, 24'h800000, 24'h7fffff, 16'hffff, 32'h7ffffffe, 0);
        send_point(24'h800000, 24'h800000, 24'h800000, 16'hffff, 32'h12345678, 1);
        drain();
    endtask

    task automatic test_view_settings;
        // tilted axis, out-of-range axis, then zero axis
        set_view(16'h2d41, 16'h0000, 16'h2d41);
        send_point(24'h000000, 24'h000000, 24'h000000, 16'h0300, 32'h0000ff00, 0);
        send_point(24'h000300, 24'h000700, 24'hfff000, 16'h0300, 32'h00ff0000, 0);
        send_point(24'h001300, 24'h000100, 24'hffe000, 16'h0300, 32'hff000000, 1);
        set_view(16'h8000, 16'h7fff, 16'hc000);
        send_point(24'h100000, 24'hf00000, 24'h000001, 16'h0a00, 32'h0f0f0f0f, 0);
        send_point(24'h0fff00, 24'hf00100, 24'h000201, 16'h0a00, 32'hf0f0f0f0, 1);
        set_view(16'h0000, 16'h0000, 16'h0000);
        send_point(24'h000000, 24'h000000, 24'h000000, 16'h0500, 32'h00000001, 0);
        send_point(24'h000400, 24'h000400, 24'h000000, 16'h0500, 32'h00000002, 1);
        set_view(16'h0000, 16'h4000, 16'h0000);
    endtask

    task automatic random_trails(input int n_items);
        int len, sent;
        longint bx, by, bz;
        logic [POS_W-1:0] x, y, z;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 6);
            bx = $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
            by = $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
            bz = $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(7))
                    0: begin
                        x = POS_W'($urandom); y = POS_W'($urandom); z = POS_W'($urandom);
                    end
                    1: begin
                        x = bx[POS_W-1:0]; y = by[POS_W-1:0]; z = bz[POS_W-1:0];
                    end
                    default: begin
                        bx = bx + $signed($urandom_range(0, 8191)) - 4096;
                        by = by + $signed($urandom_range(0, 8191)) - 4096;
                        bz = bz + $signed($urandom_range(0, 8191)) - 4096;
                        x = bx[POS_W-1:0]; y = by[POS_W-1:0]; z = bz[POS_W-1:0];
                    end
                endcase
                send_point(x, y, z, WD_W'($urandom), $urandom, i == len - 1);
                sent++;
            end
        end
    endtask

    task automatic test_random;
        int modes [0:3][0:1];
        modes = '{'{0, 0}, '{73, 0}, '{0, 73}, '{8, 8}};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = modes[p][0];
            recv_stall_pct = modes[p][1];
            random_trails(20);
            if (p == 1) set_view(UV_W'($urandom), UV_W'($urandom), UV_W'($urandom));
            if (p == 2) set_view(16'h0000, 16'h0000, 16'h4000);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure;
        // receiver holds off while a trail keeps coming
        hold_req = 4000;
        @(posedge i_clk);
        for (int i = 0; i < 6; i++)
            send_point(POS_W'(i * 'h300), POS_W'(i * 'h100), 24'h000000, 16'h0400,
                       $urandom, i == 5);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYC) @(posedge i_clk);
        test_directed();
        test_view_settings();
        test_random();
        test_backpressure();
        drain();
        if (n_fail == 0) begin
            $display("[ribbon_strip_vertex_expander_core] OK");
        end else begin
            $display("[ribbon_strip_vertex_expander_core] ERROR");
        end
        $finish;
    end

endmodule
